// ===== rtl/tmsf_pkg.sv =====
// shared constants and types for the trimmed mean sample filter
package tmsf_pkg;

    // fixed port widths
    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 12;
    localparam int SETTLE_W = 4;

    // settle register limits
    localparam int                SETTLE_MAX   = (1 << SETTLE_W) - 1;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 4'd2;

    // parameter defaults
    localparam int DEF_AVG_LOG2    = 4;
    localparam int DEF_SAMPLE_BITS = 12;

    // burst status from the accumulator to the top level
    typedef struct packed {
        logic              last;
        logic [MEAN_W-1:0] mean;
    } tmsf_res_t;

endpackage

// ===== rtl/trimmed_mean_sample_filter.sv =====
// Trimmed mean sample filter top level: input register, burst accumulator,
// result register.
//
// Samples arrive on the s_ channel (s_valid, s_ready, s_sample), one transfer
// per cycle while s_ready is high. Each burst begins with settle_discard
// ignored samples, then 2^AVG_LOG2 + 2 kept samples; on the last kept sample
// the sum less the largest and smallest, shifted right by AVG_LOG2, leaves on
// the m_ channel (m_valid, m_ready, m_mean_value). Other samples give no result.
// settle_discard is written through cfg_wr_en / cfg_wr_data; a write also
// restarts the burst. Write it only while the block is idle.
// A sample is registered in the input register at its transfer; the result
// of a burst's last kept sample is then registered in the output register.
// Throughput: one sample per cycle unless s_ready drops (see below), set by the single accumulator stage.
// Reset (aresetn low, synchronous) sets settle_discard to 2, clears the
// burst and empties both registers.
// When the receiver stalls, the result waits in the output register; samples
// keep flowing until a second result would need that register, and then
// s_ready drops until the waiting result is taken.
module trimmed_mean_sample_filter #(
    parameter int AVG_LOG2    = tmsf_pkg::DEF_AVG_LOG2,
    parameter int SAMPLE_BITS = tmsf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tmsf_pkg::SETTLE_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmsf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tmsf_pkg::MEAN_W-1:0]   m_mean_value
);

    logic                         in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0]       in_sample_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [tmsf_pkg::MEAN_W-1:0]  out_mean_reg;
    logic                         out_free;
    logic                         drain;
    logic                         s_xfer;
    tmsf_pkg::tmsf_res_t          res;

    // stage handshakes
    assign out_free = !out_valid_reg || m_ready;
    assign drain    = in_valid_reg && (!res.last || out_free);
    assign s_ready  = !in_valid_reg || drain;
    assign s_xfer   = s_valid && s_ready;

    // burst accumulator
    tmsf_accum #(
        .AVG_LOG2    (AVG_LOG2),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (drain),
        .sample      (in_sample_reg),
        .res         (res)
    );

    // input register valid
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (drain) begin
            in_valid_next = 1'b0;
        end
    end

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (drain && res.last) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, sample bits above SAMPLE_BITS dropped
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_sample_reg <= SAMPLE_BITS'(s_sample);
        end
        if (drain && res.last) begin
            out_mean_reg <= res.mean;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_mean_value = out_mean_reg;

`ifndef SYNTHESIS
    // a finished burst always lands in the output register
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        drain && res.last |=> out_valid_reg)
        else $error("finished burst did not reach output register");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(drain && res.last))
        else $error("waiting result overwritten");

    // an empty input register always takes a sample
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");
`endif

endmodule

// ===== rtl/tmsf_accum.sv =====
// burst accumulator: settle count, running sum, min and max tracking, trimmed mean
module tmsf_accum #(
    parameter int AVG_LOG2    = tmsf_pkg::DEF_AVG_LOG2,
    parameter int SAMPLE_BITS = tmsf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tmsf_pkg::SETTLE_W-1:0] cfg_wr_data,
    input  logic                          step_en,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output tmsf_pkg::tmsf_res_t           res
);

    localparam int KEEP  = (1 << AVG_LOG2) + 2;
    localparam int CNT_W = $clog2(tmsf_pkg::SETTLE_MAX + KEEP + 1);
    localparam int SUM_W = SAMPLE_BITS + AVG_LOG2 + 1;
    localparam int EXT_W = SUM_W + tmsf_pkg::MEAN_W;

    logic [tmsf_pkg::SETTLE_W-1:0] settle_reg, settle_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]        max_reg, max_next;
    logic [SAMPLE_BITS-1:0]        min_reg, min_next;

    logic [CNT_W-1:0]       settle_ext;
    logic [CNT_W-1:0]       limit;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   settling;
    logic [SUM_W-1:0]       sum_new;
    logic [SAMPLE_BITS-1:0] max_new;
    logic [SAMPLE_BITS-1:0] min_new;
    logic [SUM_W-1:0]       trimmed;
    logic [EXT_W-1:0]       trim_ext;

    // burst position
    assign settle_ext = CNT_W'(settle_reg);
    assign limit      = settle_ext + CNT_W'(KEEP);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign settling   = (cnt_reg < settle_ext);

    // kept sample folded into the burst
    assign sum_new = sum_reg + SUM_W'(sample);
    assign max_new = (sample > max_reg) ? sample : max_reg;
    assign min_new = (sample < min_reg) ? sample : min_reg;

    // drop largest and smallest, then divide by the power of two
    assign trimmed  = sum_new - SUM_W'(max_new) - SUM_W'(min_new);
    assign trim_ext = EXT_W'(trimmed);

    assign res.last = !settling && (cnt_inc == limit);
    assign res.mean = trim_ext[AVG_LOG2 +: tmsf_pkg::MEAN_W];

    // next burst state
    always_comb begin
        settle_next = settle_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        if (cfg_wr_en) begin
            settle_next = cfg_wr_data;
            cnt_next    = '0;
            sum_next    = '0;
            max_next    = '0;
            min_next    = '1;
        end else if (step_en) begin
            if (settling) begin
                cnt_next = cnt_inc;
            end else if (res.last) begin
                cnt_next = '0;
                sum_next = '0;
                max_next = '0;
                min_next = '1;
            end else begin
                cnt_next = cnt_inc;
                sum_next = sum_new;
                max_next = max_new;
                min_next = min_new;
            end
        end
    end

    // burst state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= tmsf_pkg::SETTLE_RESET;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            max_reg    <= '0;
            min_reg    <= '1;
        end else begin
            settle_reg <= settle_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
        end
    end

`ifndef SYNTHESIS
    // the count never runs past the end of a burst
    a_cnt_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < limit)
        else $error("burst count past end of burst");

    // a finished burst leaves the state cleared
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.last |=> cnt_reg == '0 && sum_reg == '0)
        else $error("burst state not cleared after last sample");

    // while settling nothing is accumulated
    a_no_sum_settling: assert property (@(posedge aclk) disable iff (!aresetn)
        settling |-> sum_reg == '0 && max_reg == '0)
        else $error("accumulation during settling");
`endif

endmodule
